// ===== design/evts_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Task scheduler package
// Shared types and constants for the deadline / vruntime task scheduler.
// ---------------------------------------------------------------------------
package evts_pkg;

    localparam logic [2:0] OP_CREATE   = 3'd0;
    localparam logic [2:0] OP_PICK     = 3'd1;
    localparam logic [2:0] OP_EXIT     = 3'd2;
    localparam logic [2:0] OP_YIELD    = 3'd3;
    localparam logic [2:0] OP_AFFINITY = 3'd4;

    localparam logic [1:0] RS_READY   = 2'd0;
    localparam logic [1:0] RS_RUNNING = 2'd1;
    localparam logic [1:0] RS_EXITED  = 2'd3;

    // Number of cpu numbers that the 5-bit cpu field can carry.
    localparam int CPU_IDS = 32;

    localparam int IN_BITS  = 3 + 32 + 5 + 1 + 64 + 32;
    localparam int IN_BYTES = (IN_BITS + 7) / 8;
    localparam int OUT_BITS  = 32 + 1 + 1 + 9;
    localparam int OUT_BYTES = (OUT_BITS + 7) / 8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD,
        ST_SCAN,
        ST_PASS2,
        ST_WRITE,
        ST_OUT
    } t_state;

endpackage

// ===== design/edf_vruntime_task_scheduler.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Task scheduler top level
// Task table with create, pick, exit, yield and set-affinity operations.
// ---------------------------------------------------------------------------
// Usage:
//   The s_axis channel carries one operation per transfer; tdata holds, from
//   the lowest bit: opcode, task_id, cpu, task_class, deadline, affinity_mask.
//   The m_axis channel returns one result per operation; tdata holds, from
//   the lowest bit: result_id, status, chosen_realtime, live_tasks.
//   The cfg channel writes yield_penalty (16 bits) while the block is idle.
// Timing:
//   One compare unit visits the table one slot per cycle. After the accepting
//   edge the block primes the memory read (ST_RD), scans up to TABLE_SLOTS
//   slots (ST_SCAN), updates the table (ST_WRITE) and presents the result
//   (ST_OUT). Create, exit, set affinity and yield stop at the first match.
//   A pick that falls back to the vruntime pass goes through ST_PASS2 and
//   scans again. A bad opcode, a pick or yield with a bad cpu, or a yield
//   with no current task skips the scan and goes from ST_RD to ST_OUT;
//   s_axis_tready stays low until the result transfer completes, and a
//   stalled m_axis holds its result.
// Reset:
//   Synchronous active-low reset clears the active bits, the fill count, the
//   cpu current ids, the task count, sets the id counter to 1 and the penalty
//   to 10. No clearing pass: slots at or above the fill count read as id 0.
// ---------------------------------------------------------------------------
module edf_vruntime_task_scheduler #(
    parameter int TABLE_SLOTS = 256,
    parameter int CPU_COUNT   = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // opcode, task_id, cpu, task_class, deadline, affinity_mask
    input  logic [evts_pkg::IN_BYTES*8-1:0]   s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // result_id, status, chosen_realtime, live_tasks
    output logic [evts_pkg::OUT_BYTES*8-1:0]  m_axis_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [15:0]                       cfg_data
);

    localparam int AW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CW = $clog2(TABLE_SLOTS + 1);

    // Flip-flop state with reset values.
    logic [TABLE_SLOTS-1:0]       r_active;
    logic [31:0]                  r_cur [evts_pkg::CPU_IDS];
    logic [31:0]                  r_next_id;
    logic [CW-1:0]                r_count;
    logic [15:0]                  r_pen;
    // Create always takes the lowest free slot, so the slots it has ever
    // written form a prefix; this counts them.
    logic [CW-1:0]                r_fill;

    // Memories.
    logic [31:0] m_id  [TABLE_SLOTS];
    logic [63:0] m_dl  [TABLE_SLOTS];
    logic [63:0] m_vr  [TABLE_SLOTS];
    logic [31:0] m_af  [TABLE_SLOTS];
    logic [4:0]  m_hc  [TABLE_SLOTS];
    logic        m_cls [TABLE_SLOTS];
    logic [1:0]  m_rs  [TABLE_SLOTS];
    logic [31:0] r_rd_id;
    logic [63:0] r_rd_dl, r_rd_vr;
    logic [31:0] r_rd_af;
    logic [4:0]  r_rd_hc;
    logic        r_rd_cls;
    logic [1:0]  r_rd_rs;

    evts_pkg::t_state r_st, n_st;
    logic [AW:0]  r_idx;      // read address that was presented last cycle
    logic [AW:0]  r_addr;
    logic [2:0]   r_op;
    logic [31:0]  r_tid;
    logic [4:0]   r_cpu;
    logic         r_cls;
    logic [63:0]  r_dl;
    logic [31:0]  r_mask;
    logic         r_found;
    logic [AW-1:0] r_best;
    logic [31:0]  r_bid;
    logic [63:0]  r_key;
    logic         r_pass;     // 1 = deadline pass
    logic [31:0]  r_oid;
    logic         r_ost;
    logic         r_ort;

    logic [AW-1:0] s_slot;
    logic          s_elig, s_hit, s_last, cpu_ok;
    logic [31:0]   s_id;
    logic [63:0]   s_key;

    assign s_slot = r_idx[AW-1:0];
    assign s_last = (r_idx == (AW+1)'(TABLE_SLOTS - 1));
    assign cpu_ok = ({27'd0, r_cpu} < 32'(CPU_COUNT));
    assign s_id   = (CW'(s_slot) < r_fill) ? r_rd_id : 32'd0;
    assign s_key  = r_pass ? r_rd_dl : r_rd_vr;
    assign s_elig = r_active[s_slot] && (r_rd_rs == evts_pkg::RS_READY) &&
                    (r_rd_cls == r_pass) && r_rd_af[r_cpu] && (r_rd_hc == r_cpu);

    always_comb begin
        unique case (r_op)
            evts_pkg::OP_CREATE:   s_hit = !r_active[s_slot];
            evts_pkg::OP_PICK:     s_hit = s_elig && (!r_found || s_key < r_key);
            evts_pkg::OP_YIELD:    s_hit = (s_id == r_cur[r_cpu]);
            default:               s_hit = r_active[s_slot] && (s_id == r_tid);
        endcase
    end

    assign s_axis_tready = (r_st == evts_pkg::ST_IDLE);
    assign cfg_ready     = (r_st == evts_pkg::ST_IDLE);
    assign m_axis_tvalid = (r_st == evts_pkg::ST_OUT);
    assign m_axis_tdata  = {{(evts_pkg::OUT_BYTES*8-evts_pkg::OUT_BITS){1'b0}},
                            9'(r_count), r_ort, r_ost, r_oid};

    always_ff @(posedge i_clk) begin
        r_rd_id  <= m_id[r_addr[AW-1:0]];
        r_rd_dl  <= m_dl[r_addr[AW-1:0]];
        r_rd_vr  <= m_vr[r_addr[AW-1:0]];
        r_rd_af  <= m_af[r_addr[AW-1:0]];
        r_rd_hc  <= m_hc[r_addr[AW-1:0]];
        r_rd_cls <= m_cls[r_addr[AW-1:0]];
        r_rd_rs  <= m_rs[r_addr[AW-1:0]];
        if (r_st == evts_pkg::ST_WRITE && r_found) begin
            if (r_op == evts_pkg::OP_CREATE) begin
                m_id[r_best]  <= r_next_id;
                m_dl[r_best]  <= r_dl;
                m_vr[r_best]  <= 64'd0;
                m_af[r_best]  <= 32'hFFFF_FFFF;
                m_hc[r_best]  <= r_cpu;
                m_cls[r_best] <= r_cls;
                m_rs[r_best]  <= evts_pkg::RS_READY;
            end else if (r_op == evts_pkg::OP_PICK) begin
                m_rs[r_best] <= evts_pkg::RS_RUNNING;
            end else if (r_op == evts_pkg::OP_EXIT) begin
                m_rs[r_best] <= evts_pkg::RS_EXITED;
            end else if (r_op == evts_pkg::OP_YIELD) begin
                m_vr[r_best] <= r_key + {48'd0, r_pen};
                m_rs[r_best] <= evts_pkg::RS_READY;
            end else if (r_op == evts_pkg::OP_AFFINITY) begin
                m_af[r_best] <= r_mask;
            end
        end
    end

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            evts_pkg::ST_IDLE: if (s_axis_tvalid) n_st = evts_pkg::ST_RD;
            evts_pkg::ST_RD: begin
                if (r_op > evts_pkg::OP_AFFINITY) n_st = evts_pkg::ST_OUT;
                else if ((r_op == evts_pkg::OP_PICK || r_op == evts_pkg::OP_YIELD)
                         && !cpu_ok) n_st = evts_pkg::ST_OUT;
                else if (r_op == evts_pkg::OP_YIELD &&
                         r_cur[r_cpu] == 32'd0) n_st = evts_pkg::ST_OUT;
                else n_st = evts_pkg::ST_SCAN;
            end
            evts_pkg::ST_SCAN: begin
                if (r_op == evts_pkg::OP_PICK) begin
                    if (s_last) n_st = (r_pass && !(r_found || s_hit)) ?
                                       evts_pkg::ST_PASS2 : evts_pkg::ST_WRITE;
                end else if (s_hit || s_last) n_st = evts_pkg::ST_WRITE;
            end
            evts_pkg::ST_PASS2: n_st = evts_pkg::ST_SCAN;
            evts_pkg::ST_WRITE: n_st = evts_pkg::ST_OUT;
            evts_pkg::ST_OUT:   if (m_axis_tready) n_st = evts_pkg::ST_IDLE;
            default:            n_st = evts_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st      <= evts_pkg::ST_IDLE;
            r_active  <= '0;
            r_fill    <= '0;
            for (int k = 0; k < evts_pkg::CPU_IDS; k++) r_cur[k] <= 32'd0;
            r_next_id <= 32'd1;
            r_count   <= '0;
            r_pen     <= 16'd10;
            r_found   <= 1'b0;
        end else begin
            r_st <= n_st;
            if (cfg_valid && cfg_ready) r_pen <= cfg_data;
            unique case (r_st)
                evts_pkg::ST_IDLE: begin
                    r_op   <= s_axis_tdata[2:0];
                    r_tid  <= s_axis_tdata[34:3];
                    r_cpu  <= s_axis_tdata[39:35];
                    r_cls  <= s_axis_tdata[40];
                    r_dl   <= s_axis_tdata[104:41];
                    r_mask <= s_axis_tdata[136:105];
                    r_addr <= '0;
                    r_idx  <= '0;
                    r_found <= 1'b0;
                    r_pass <= 1'b1;
                    r_ort  <= 1'b0;
                    r_oid  <= 32'd0;
                    r_ost  <= 1'b1;
                end
                evts_pkg::ST_RD: r_addr <= r_addr + 1'b1;
                evts_pkg::ST_SCAN: begin
                    r_idx  <= r_addr;
                    r_addr <= r_addr + 1'b1;
                    if (s_hit && !(r_found && r_op != evts_pkg::OP_PICK)) begin
                        r_found <= 1'b1;
                        r_best  <= s_slot;
                        r_bid   <= s_id;
                        r_key   <= (r_op == evts_pkg::OP_YIELD) ? r_rd_vr : s_key;
                    end
                    if (r_op == evts_pkg::OP_PICK && s_last) begin
                        r_addr <= '0;
                        r_idx  <= '0;
                    end
                end
                evts_pkg::ST_PASS2: begin
                    r_pass <= 1'b0;
                    r_addr <= r_addr + 1'b1;
                end
                evts_pkg::ST_WRITE: begin
                    r_ost <= !r_found;
                    unique case (r_op)
                        evts_pkg::OP_CREATE: if (r_found) begin
                            r_active[r_best] <= 1'b1;
                            if (CW'(r_best) == r_fill) r_fill <= r_fill + 1'b1;
                            r_next_id        <= r_next_id + 32'd1;
                            r_count          <= r_count + 1'b1;
                            r_oid            <= r_next_id;
                        end
                        evts_pkg::OP_PICK: begin
                            r_cur[r_cpu] <= r_found ? r_bid : 32'd0;
                            if (r_found) begin
                                r_oid <= r_bid;
                                r_ort <= r_pass;
                            end
                        end
                        evts_pkg::OP_EXIT: if (r_found) begin
                            r_active[r_best] <= 1'b0;
                            r_count          <= r_count - 1'b1;
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_one_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid)) else $error("ready while result pending");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_SLOTS)) else $error("task count overflow");
`endif

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Task scheduler regression
// Drives create, pick, exit, yield, set-affinity and bad operations into the
// scheduler, predicts every result with a behavioral task table and checks
// each result transfer field by field, under random idling on both channels.
// ---------------------------------------------------------------------------
module tb_top;

    localparam int SLOTS = 256;
    localparam int CPUS  = 32;
    localparam int DRAIN_CYCLES = 2 * SLOTS + 40;
    localparam logic [2:0] OP_BAD_LO = 3'd5;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] tid;
        logic [4:0]  cpu;
        logic        cls;
        logic [63:0] dl;
        logic [31:0] mask;
    } t_sched_op;

    // Ordered so that result_id lands in the lowest bits, as on tdata.
    typedef struct packed {
        logic [8:0]  live;
        logic        rt;
        logic        status;
        logic [31:0] rid;
    } t_sched_res;

    logic                               i_clk;
    logic                               i_rst_n;
    logic                               s_axis_tvalid;
    logic                               s_axis_tready;
    logic [evts_pkg::IN_BYTES*8-1:0]    s_axis_tdata;
    logic                               m_axis_tvalid;
    logic                               m_axis_tready;
    logic [evts_pkg::OUT_BYTES*8-1:0]   m_axis_tdata;
    logic                               cfg_valid;
    logic                               cfg_ready;
    logic [15:0]                        cfg_data;

    // Shadow task table.
    logic        tbl_active  [SLOTS];
    logic [31:0] tbl_id      [SLOTS];
    logic        tbl_class   [SLOTS];
    logic [1:0]  tbl_rs      [SLOTS];
    logic [63:0] tbl_deadline[SLOTS];
    logic [63:0] tbl_vrt     [SLOTS];
    logic [31:0] tbl_aff     [SLOTS];
    logic [4:0]  tbl_home    [SLOTS];
    logic [31:0] cur_task    [CPUS];
    logic [31:0] next_id;
    int          live_count;
    logic [15:0] penalty;

    t_sched_res  pending_results[$];
    int          fail_count;
    int          send_idle_pct;
    int          recv_idle_pct;

    edf_vruntime_task_scheduler dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    function automatic logic pick_candidate(int i, logic [4:0] cpu, logic cls);
        return tbl_active[i] && tbl_rs[i] == evts_pkg::RS_READY && tbl_class[i] == cls &&
               tbl_aff[i][cpu] && tbl_home[i] == cpu;
    endfunction

    // Applies one operation to the shadow table and returns its result.
    function automatic t_sched_res schedule_step(t_sched_op o);
        t_sched_res r;
        int best;
        r = '0;
        r.status = 1'b1;
        best = -1;
        case (o.op)
            evts_pkg::OP_CREATE: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (!tbl_active[i]) begin
                        tbl_id[i]       = next_id;
                        next_id         = next_id + 1;
                        tbl_class[i]    = o.cls;
                        tbl_deadline[i] = o.dl;
                        tbl_vrt[i]      = '0;
                        tbl_rs[i]       = evts_pkg::RS_READY;
                        tbl_active[i]   = 1'b1;
                        tbl_aff[i]      = '1;
                        tbl_home[i]     = o.cpu;
                        live_count++;
                        r.rid    = tbl_id[i];
                        r.status = 1'b0;
                        break;
                    end
                end
            end
            evts_pkg::OP_PICK: begin
                for (int i = 0; i < SLOTS; i++)
                    if (pick_candidate(i, o.cpu, 1'b1) &&
                        (best < 0 || tbl_deadline[i] < tbl_deadline[best]))
                        best = i;
                if (best >= 0) begin
                    r.rt = 1'b1;
                end else begin
                    for (int i = 0; i < SLOTS; i++)
                        if (pick_candidate(i, o.cpu, 1'b0) &&
                            (best < 0 || tbl_vrt[i] < tbl_vrt[best]))
                            best = i;
                end
                if (best >= 0) begin
                    tbl_rs[best]   = evts_pkg::RS_RUNNING;
                    cur_task[o.cpu] = tbl_id[best];
                    r.rid    = tbl_id[best];
                    r.status = 1'b0;
                end else begin
                    cur_task[o.cpu] = '0;
                end
            end
            evts_pkg::OP_EXIT: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (tbl_active[i] && tbl_id[i] == o.tid) begin
                        tbl_rs[i]     = evts_pkg::RS_EXITED;
                        tbl_active[i] = 1'b0;
                        live_count--;
                        r.status = 1'b0;
                        break;
                    end
                end
            end
            evts_pkg::OP_YIELD: begin
                // The lookup matches any slot, active or not.
                if (cur_task[o.cpu] != '0) begin
                    for (int i = 0; i < SLOTS; i++) begin
                        if (tbl_id[i] == cur_task[o.cpu]) begin
                            tbl_rs[i]  = evts_pkg::RS_READY;
                            tbl_vrt[i] = tbl_vrt[i] + 64'(penalty);
                            r.status = 1'b0;
                            break;
                        end
                    end
                end
            end
            evts_pkg::OP_AFFINITY: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (tbl_active[i] && tbl_id[i] == o.tid) begin
                        tbl_aff[i] = o.mask;
                        r.status = 1'b0;
                        break;
                    end
                end
            end
            default: ;
        endcase
        r.live = live_count[8:0];
        return r;
    endfunction

    task automatic send_op(t_sched_op o);
        logic [evts_pkg::IN_BYTES*8-1:0] word;
        word = '0;
        word[2:0]     = o.op;
        word[34:3]    = o.tid;
        word[39:35]   = o.cpu;
        word[40]      = o.cls;
        word[104:41]  = o.dl;
        word[136:105] = o.mask;
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = word;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_results.push_back(schedule_step(o));
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_penalty(logic [15:0] value);
        drain_results();
        cfg_valid = 1'b1;
        cfg_data  = value;
        do @(posedge i_clk); while (!cfg_ready);
        penalty = value;
        @(negedge i_clk);
        cfg_valid = 1'b0;
    endtask

    function automatic t_sched_op make_op(logic [2:0] op, logic [31:0] tid, logic [4:0] cpu,
                                          logic cls, logic [63:0] dl, logic [31:0] mask);
        t_sched_op o;
        o.op = op; o.tid = tid; o.cpu = cpu; o.cls = cls; o.dl = dl; o.mask = mask;
        return o;
    endfunction

    function automatic logic [31:0] some_live_id();
        for (int t = 0; t < 64; t++) begin
            int s;
            s = $urandom_range(SLOTS - 1);
            if (tbl_active[s]) return tbl_id[s];
        end
        return {$urandom};
    endfunction

    task automatic test_directed_ops();
        send_op(make_op(evts_pkg::OP_CREATE, '1, 5'd0, 1'b0, 64'd77, '0));
        send_op(make_op(evts_pkg::OP_CREATE, '0, 5'd0, 1'b1, '1, '1));
        send_op(make_op(evts_pkg::OP_CREATE, 32'h5555_AAAA, 5'd0, 1'b1, '0, 32'hA5A5_5A5A));
        send_op(make_op(evts_pkg::OP_CREATE, '0, 5'd31, 1'b0, '1, '0));
        send_op(make_op(evts_pkg::OP_PICK, '0, 5'd0, 1'b0, '0, '0));
        send_op(make_op(evts_pkg::OP_PICK, '0, 5'd0, 1'b0, '0, '0));
        send_op(make_op(evts_pkg::OP_PICK, '0, 5'd0, 1'b0, '0, '0));
        // Nothing left for cpu 0, so its current task becomes idle.
        send_op(make_op(evts_pkg::OP_PICK, '0, 5'd0, 1'b0, '0, '0));
        send_op(make_op(evts_pkg::OP_YIELD, '0, 5'd0, 1'b0, '0, '0));
        send_op(make_op(evts_pkg::OP_YIELD, '0, 5'd7, 1'b0, '0, '0));
        send_op(make_op(evts_pkg::OP_PICK, '0, 5'd31, 1'b1, '1, '1));
        send_op(make_op(evts_pkg::OP_YIELD, '1, 5'd31, 1'b1, '1, '1));
        send_op(make_op(evts_pkg::OP_AFFINITY, 32'd4, 5'd0, 1'b0, '0, 32'h7FFF_FFFF));
        send_op(make_op(evts_pkg::OP_PICK, '0, 5'd31, 1'b0, '0, '0));
        send_op(make_op(evts_pkg::OP_AFFINITY, 32'hDEAD_BEEF, 5'd0, 1'b0, '0, '1));
        send_op(make_op(evts_pkg::OP_EXIT, 32'd2, 5'd0, 1'b0, '0, '0));
        send_op(make_op(evts_pkg::OP_EXIT, 32'd2, 5'd0, 1'b0, '0, '0));
        // The pick finds no ready task for cpu 0, so the yield has no current task.
        send_op(make_op(evts_pkg::OP_PICK, '0, 5'd0, 1'b0, '0, '0));
        send_op(make_op(evts_pkg::OP_YIELD, '0, 5'd0, 1'b0, '0, '0));
        for (int k = 0; k < 3; k++)
            send_op(make_op(OP_BAD_LO + 3'(k), '1, 5'd31, 1'b1, '1, '1));
    endtask

    task automatic test_table_full();
        while (live_count < SLOTS)
            send_op(make_op(evts_pkg::OP_CREATE, '0, 5'($urandom_range(3)), 1'($urandom),
                            {$urandom, $urandom}, '0));
        send_op(make_op(evts_pkg::OP_CREATE, '0, 5'd1, 1'b1, '0, '0));
        send_op(make_op(evts_pkg::OP_PICK, '0, 5'd1, 1'b0, '0, '0));
        while (live_count > 200)
            send_op(make_op(evts_pkg::OP_EXIT, some_live_id(), 5'd0, 1'b0, '0, '0));
    endtask

    task automatic test_random_ops(int n_items, int s_idle, int r_idle);
        t_sched_op o;
        int sel;
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        for (int n = 0; n < n_items; n++) begin
            sel = $urandom_range(99);
            o.tid  = ($urandom_range(9) < 8) ? some_live_id() : $urandom;
            o.cpu  = ($urandom_range(9) < 8) ? 5'($urandom_range(3)) : 5'($urandom);
            o.cls  = 1'($urandom);
            case ($urandom_range(9))
                0: o.dl = '1;
                1: o.dl = 64'($urandom_range(15));
                default: o.dl = {$urandom, $urandom};
            endcase
            o.mask = $urandom;
            if (sel < 24)
                o.op = (live_count > 200) ? evts_pkg::OP_EXIT : evts_pkg::OP_CREATE;
            else if (sel < 50) o.op = evts_pkg::OP_PICK;
            else if (sel < 63) o.op = evts_pkg::OP_EXIT;
            else if (sel < 80) o.op = evts_pkg::OP_YIELD;
            else if (sel < 94) o.op = evts_pkg::OP_AFFINITY;
            else               o.op = 3'($urandom_range(7, 5));
            send_op(o);
            if (n == n_items / 2) drain_results();
        end
    endtask

    always @(negedge i_clk)
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge i_clk) begin
        t_sched_res want;
        t_sched_res got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[42:0];
            if (pending_results.size() == 0) begin
                $error("result transfer with nothing expected: %h", got);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (got.rid !== want.rid) begin
                    $error("result_id: expected %0d, got %0d", want.rid, got.rid);
                    fail_count++;
                end
                if (got.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    fail_count++;
                end
                if (got.rt !== want.rt) begin
                    $error("chosen_realtime: expected %0d, got %0d", want.rt, got.rt);
                    fail_count++;
                end
                if (got.live !== want.live) begin
                    $error("live_tasks: expected %0d, got %0d", want.live, got.live);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            tbl_active[i] = 1'b0; tbl_id[i] = '0; tbl_class[i] = 1'b0;
            tbl_rs[i] = evts_pkg::RS_READY;
            tbl_deadline[i] = '0; tbl_vrt[i] = '0; tbl_aff[i] = '0; tbl_home[i] = '0;
        end
        for (int c = 0; c < CPUS; c++) cur_task[c] = '0;
        next_id = 32'd1;
        live_count = 0;
        penalty = 16'd10;
        fail_count = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_ops();
        test_table_full();
        write_penalty(16'hFFFF);
        test_random_ops(120, 37, 69);
        write_penalty(16'h0000);
        test_random_ops(120, 69, 37);
        write_penalty(16'($urandom));
        test_random_ops(120, 0, 0);
        drain_results();

        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("edf_vruntime_task_scheduler regression: pass");
        end else begin
            if (pending_results.size() != 0)
                $error("%0d expected results never arrived", pending_results.size());
            $display("edf_vruntime_task_scheduler regression: fail");
        end
        $finish;
    end

    initial begin
        #200_000_000;
        $display("edf_vruntime_task_scheduler regression: fail");
        $finish;
    end

endmodule

// ===== files.f =====
design/evts_pkg.sv
design/edf_vruntime_task_scheduler.sv
tb/tb_top.sv
